// ----- src/h2sst_pkg.sv -----
// Package for the HTTP/2 stream state tracker: codes, table lookups and the
// transition helper shared by the next-state logic and the top level.
// Depends on nothing.
package h2sst_pkg;

   // Operation selector carried in tuser.
   localparam logic [1:0] OP_SEND  = 2'd0;
   localparam logic [1:0] OP_RECV  = 2'd1;
   localparam logic [1:0] OP_EVENT = 2'd2;

   // Frame type codes.
   localparam logic [7:0] FT_DATA          = 8'd0;
   localparam logic [7:0] FT_HEADERS       = 8'd1;
   localparam logic [7:0] FT_PRIORITY      = 8'd2;
   localparam logic [7:0] FT_RST_STREAM    = 8'd3;
   localparam logic [7:0] FT_SETTINGS      = 8'd4;
   localparam logic [7:0] FT_PUSH_PROMISE  = 8'd5;
   localparam logic [7:0] FT_PING          = 8'd6;
   localparam logic [7:0] FT_GOAWAY        = 8'd7;
   localparam logic [7:0] FT_WINDOW_UPDATE = 8'd8;
   localparam logic [7:0] FT_CONTINUATION  = 8'd9;
   localparam logic [7:0] NUM_FRAMES       = 8'd10;

   // Stream event codes.
   localparam logic [1:0] EV_CLOSED_LOCAL  = 2'd0;
   localparam logic [1:0] EV_CLOSED_REMOTE = 2'd1;
   localparam logic [1:0] EV_CANCEL        = 2'd2;
   localparam logic [1:0] EV_EOS_SENT      = 2'd3;

   // Stream states.
   localparam logic [2:0] ST_IDLE        = 3'd0;
   localparam logic [2:0] ST_RSVD_REMOTE = 3'd1;
   localparam logic [2:0] ST_RSVD_LOCAL  = 3'd2;
   localparam logic [2:0] ST_OPEN        = 3'd3;
   localparam logic [2:0] ST_HALF_REMOTE = 3'd4;
   localparam logic [2:0] ST_HALF_LOCAL  = 3'd5;
   localparam logic [2:0] ST_CLOSED      = 3'd6;
   localparam logic [2:0] ST_CLEANUP     = 3'd7;

   // Stored error codes.
   localparam logic [3:0] ERR_NONE     = 4'd0;
   localparam logic [3:0] ERR_PROTOCOL = 4'd1;
   localparam logic [3:0] ERR_INTERNAL = 4'd2;

   // A table entry is a next state, or one of the two special codes.
   typedef logic [3:0] entry_type;
   localparam entry_type ENT_KEEP = 4'd8;
   localparam entry_type ENT_ERR  = 4'd9;

   // Working view of the stream while one transfer is evaluated.
   typedef struct packed {
      logic [2:0] state;
      logic [3:0] err;
      logic       invalid;
      logic       rst;
   } track_type;

   // One result item.
   typedef struct packed {
      logic       is_closed;
      logic       state_changed;
      logic       reset_now;
      logic [3:0] reset_error;
      logic       status_code;
      logic [2:0] stream_state;
   } rsp_type;

   function automatic entry_type to_entry(input logic [2:0] st);
      return {1'b0, st};
   endfunction

   // Transition table for frames sent on the stream.
   function automatic entry_type tx_entry(input logic [7:0] ft, input logic [2:0] st);
      entry_type e;
      e = ENT_KEEP;
      case (ft)
         FT_DATA: begin
            e = (st inside {ST_OPEN, ST_HALF_REMOTE, ST_CLOSED, ST_CLEANUP}) ? ENT_KEEP
                                                                            : ENT_ERR;
         end
         FT_HEADERS: begin
            if (st == ST_RSVD_LOCAL) e = to_entry(ST_HALF_REMOTE);
            else if (st inside {ST_IDLE, ST_RSVD_REMOTE, ST_HALF_LOCAL}) e = ENT_ERR;
            else e = ENT_KEEP;
         end
         FT_RST_STREAM: begin
            e = (st inside {ST_CLOSED, ST_CLEANUP}) ? ENT_KEEP : to_entry(ST_CLOSED);
         end
         FT_PUSH_PROMISE: begin
            e = (st == ST_IDLE) ? to_entry(ST_RSVD_LOCAL) : ENT_ERR;
         end
         FT_SETTINGS, FT_PING, FT_GOAWAY: e = ENT_ERR;
         FT_PRIORITY, FT_WINDOW_UPDATE, FT_CONTINUATION: e = ENT_KEEP;
         default: e = ENT_KEEP;
      endcase
      return e;
   endfunction

   // Transition table for frames received on the stream.
   function automatic entry_type rx_entry(input logic [7:0] ft, input logic [2:0] st);
      entry_type e;
      e = ENT_KEEP;
      case (ft)
         FT_DATA: begin
            e = (st inside {ST_IDLE, ST_RSVD_REMOTE, ST_RSVD_LOCAL, ST_HALF_REMOTE}) ? ENT_ERR
                                                                                   : ENT_KEEP;
         end
         FT_HEADERS: begin
            if (st == ST_IDLE) e = to_entry(ST_OPEN);
            else if (st == ST_RSVD_REMOTE) e = to_entry(ST_HALF_LOCAL);
            else if (st inside {ST_RSVD_LOCAL, ST_HALF_REMOTE}) e = ENT_ERR;
            else e = ENT_KEEP;
         end
         FT_RST_STREAM: begin
            if (st == ST_IDLE) e = ENT_ERR;
            else if (st inside {ST_CLOSED, ST_CLEANUP}) e = ENT_KEEP;
            else e = to_entry(ST_CLOSED);
         end
         FT_PUSH_PROMISE: begin
            e = (st == ST_IDLE) ? to_entry(ST_RSVD_REMOTE) : ENT_ERR;
         end
         FT_SETTINGS, FT_PING, FT_GOAWAY: e = ENT_ERR;
         FT_PRIORITY, FT_WINDOW_UPDATE, FT_CONTINUATION: e = ENT_KEEP;
         default: e = ENT_KEEP;
      endcase
      return e;
   endfunction

   // Transition table for stream events.
   function automatic entry_type ev_entry(input logic [1:0] ev, input logic [2:0] st);
      entry_type e;
      e = ENT_ERR;
      case (ev)
         EV_CLOSED_LOCAL: begin
            if (st == ST_OPEN) e = to_entry(ST_HALF_LOCAL);
            else if (st == ST_HALF_REMOTE) e = to_entry(ST_CLOSED);
            else e = ENT_ERR;
         end
         EV_CLOSED_REMOTE: begin
            if (st == ST_OPEN) e = to_entry(ST_HALF_REMOTE);
            else if (st == ST_HALF_LOCAL) e = to_entry(ST_CLOSED);
            else if (st inside {ST_CLOSED, ST_CLEANUP}) e = ENT_KEEP;
            else e = ENT_ERR;
         end
         EV_CANCEL: begin
            e = (st inside {ST_CLOSED, ST_CLEANUP}) ? ENT_KEEP : to_entry(ST_CLOSED);
         end
         EV_EOS_SENT: begin
            if (st == ST_IDLE) e = ENT_KEEP;
            else if (st == ST_HALF_LOCAL) e = to_entry(ST_CLOSED);
            else if (st == ST_CLOSED) e = to_entry(ST_CLEANUP);
            else e = ENT_ERR;
         end
         default: e = ENT_ERR;
      endcase
      return e;
   endfunction

   // Applies one table entry. An illegal move flags the transfer and, from an
   // open, reserved or half-closed stream, resets it with INTERNAL_ERROR.
   function automatic track_type apply_entry(input entry_type e, input track_type t);
      track_type r;
      r = t;
      if (e == ENT_ERR) begin
         r.invalid = 1'b1;
         if (t.state inside {[ST_RSVD_REMOTE:ST_HALF_LOCAL]}) begin
            r.state = ST_CLOSED;
            r.err   = ERR_INTERNAL;
            r.rst   = 1'b1;
         end
      end else if (e != ENT_KEEP) begin
         r.state = e[2:0];
      end
      return r;
   endfunction

endpackage

// ----- src/http2_stream_state_tracker.sv -----
// Top level of the HTTP/2 stream state tracker: input register, stream state
// registers and result register around the next-state logic.
// Depends on h2sst_pkg and h2sst_next.
//
// Usage: each transfer on the req channel is one frame sent (tuser = 0), one
// frame received (tuser = 1) or one stream event (tuser = 2). tdata carries
// the frame type and the event code, tlast the END_STREAM flag. Every
// request transfer yields exactly one rsp transfer holding the new stream
// state, the invalid-transition status, the stored error code and the
// reset, changed and closed flags.
// Path: a request taken is held in the input register and its result is then
// loaded into the result register. Throughput: one transfer per cycle while
// rsp is not stalled; the state register is written by the same edge that loads the result register.
// Reset: synchronous; the stream returns to idle with no stored error and
// both the input and result registers empty.
// Stall: while rsp_tready is low the result stays put, the input register
// takes one more transfer and then req_tready drops until the result moves.
module http2_stream_state_tracker
   import h2sst_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // [7:0] frame_kind, [9:8] event_code, [15:10] zero
   input  logic        req_tlast,  // end_stream
   input  logic [1:0]  req_tuser,  // [1:0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata   // [2:0] stream_state_out, [3] status_code,
                                   // [7:4] reset_error, [8] reset_now,
                                   // [9] state_changed, [10] is_closed, [15:11] zero
);

   logic       in_valid_ff;
   logic       in_valid_in;
   logic [1:0] in_op_ff;
   logic [7:0] in_ft_ff;
   logic       in_eos_ff;
   logic [1:0] in_ev_ff;
   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic [3:0] err_ff;
   logic [3:0] err_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   rsp_type    rsp_ff;
   rsp_type    rsp_in;
   logic       advance;
   logic       req_take;

   // Handshake: the held item moves on when the result register is free.
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);

   h2sst_next u_next (
      .op         (in_op_ff),
      .frame_kind (in_ft_ff),
      .end_stream (in_eos_ff),
      .event_code (in_ev_ff),
      .cur_state  (state_ff),
      .cur_err    (err_ff),
      .next_state (state_in),
      .next_err   (err_in),
      .rsp        (rsp_in)
   );

   // Control and stream state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= ST_IDLE;
         err_ff       <= ERR_NONE;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
            err_ff   <= err_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff  <= req_tuser;
         in_ft_ff  <= req_tdata[7:0];
         in_eos_ff <= req_tlast;
         in_ev_ff  <= req_tdata[9:8];
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_ff};

`ifndef SYNTHESIS
   // A reset always leaves the stream closed with an error code stored.
   a_reset_closes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.reset_now) |->
         ((rsp_ff.stream_state == ST_CLOSED) && (rsp_ff.reset_error != ERR_NONE)))
      else $error("reset_now without closed state and stored error");

   // The state register tracks the state reported in the latest result.
   a_state_matches: assert property (@(posedge clock) disable iff (reset)
      advance |=> ((state_ff == rsp_ff.stream_state) && (err_ff == rsp_ff.reset_error)))
      else $error("stream state register disagrees with result");

   // A held request is not dropped while the result side is blocked.
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff)
      else $error("held request lost under stall");

   // A result waiting on a stalled receiver is kept.
   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> (rsp_valid_ff && $stable(rsp_ff)))
      else $error("pending result lost or changed under stall");
`endif

endmodule

// ----- src/h2sst_next.sv -----
// Next-state logic of the HTTP/2 stream state tracker: one table lookup, the
// trailer check, an optional follow-on close, and the result item for one transfer.
// Depends on h2sst_pkg.
module h2sst_next
   import h2sst_pkg::*;
(
   input  logic [1:0] op,
   input  logic [7:0] frame_kind,
   input  logic       end_stream,
   input  logic [1:0] event_code,
   input  logic [2:0] cur_state,
   input  logic [3:0] cur_err,
   output logic [2:0] next_state,
   output logic [3:0] next_err,
   output rsp_type    rsp
);

   track_type start;
   track_type first;
   track_type closed;
   track_type from_event;
   track_type final_t;
   entry_type frame_entry;
   logic      is_frame;
   logic      trailer;
   logic [1:0] close_event;

   // Frame lookup, the follow-on close and the event path side by side.
   always_comb begin
      start       = '{state: cur_state, err: cur_err, invalid: 1'b0, rst: 1'b0};
      is_frame    = ((op == OP_SEND) || (op == OP_RECV)) && (frame_kind < NUM_FRAMES);
      frame_entry = (op == OP_SEND) ? tx_entry(frame_kind, cur_state)
                                    : rx_entry(frame_kind, cur_state);
      trailer     = (frame_entry != ENT_ERR) && (op == OP_RECV) &&
                    (frame_kind == FT_HEADERS) && (cur_state == ST_OPEN) && !end_stream;
      first       = apply_entry(frame_entry, start);
      close_event = (op == OP_SEND) ? EV_CLOSED_LOCAL : EV_CLOSED_REMOTE;
      closed      = apply_entry(ev_entry(close_event, first.state), first);
      from_event  = apply_entry(ev_entry(event_code, cur_state), start);

      final_t = start;
      if (is_frame) begin
         if (trailer) begin
            final_t       = start;
            final_t.state = ST_CLOSED;
            final_t.err   = ERR_PROTOCOL;
            final_t.rst   = 1'b1;
         end else if ((frame_entry != ENT_ERR) && end_stream && (frame_kind <= FT_HEADERS)) begin
            final_t = closed;
         end else begin
            final_t = first;
         end
      end else if (op == OP_EVENT) begin
         final_t = from_event;
      end
   end

   // Result item fields.
   always_comb begin
      next_state        = final_t.state;
      next_err          = final_t.err;
      rsp.stream_state  = final_t.state;
      rsp.status_code   = final_t.invalid;
      rsp.reset_error   = final_t.err;
      rsp.reset_now     = final_t.rst;
      rsp.state_changed = (final_t.state != cur_state);
      rsp.is_closed     = (final_t.state >= ST_CLOSED);
   end

endmodule

// ----- test/h2sst_checker.sv -----
// Checker for the HTTP/2 stream state tracker: watches both stream channels,
// predicts each result from its own copy of the stream state and compares.
// Depends on h2sst_pkg for the codes and the result layout.
module h2sst_checker
   import h2sst_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,
   input  logic        req_tlast,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   // Table entries: keep the state, illegal move, or a next state.
   localparam entry_type KP   = ENT_KEEP;
   localparam entry_type ER   = ENT_ERR;
   localparam entry_type N_RR = {1'b0, ST_RSVD_REMOTE};
   localparam entry_type N_RL = {1'b0, ST_RSVD_LOCAL};
   localparam entry_type N_OP = {1'b0, ST_OPEN};
   localparam entry_type N_HR = {1'b0, ST_HALF_REMOTE};
   localparam entry_type N_HL = {1'b0, ST_HALF_LOCAL};
   localparam entry_type N_CL = {1'b0, ST_CLOSED};
   localparam entry_type N_CU = {1'b0, ST_CLEANUP};
   localparam logic [31:0] ALL_KEEP = {8{KP}};
   localparam logic [31:0] ALL_ERR  = {8{ER}};

   // Model of the stream and the flags of the transfer being evaluated.
   logic [2:0] stream_now;
   logic [3:0] stream_err;
   logic       flag_bad;
   logic       flag_rst;
   int         mismatches = 0;
   rsp_type    stream_reports[$];

   // Rows hold one entry per current state, cleanup in the top nibble.
   function automatic logic [31:0] sent_row(input logic [7:0] ft);
      case (ft)
         FT_DATA:         return {KP, KP, ER, KP, KP, ER, ER, ER};
         FT_HEADERS:      return {KP, KP, ER, KP, KP, N_HR, ER, ER};
         FT_RST_STREAM:   return {KP, KP, N_CL, N_CL, N_CL, N_CL, N_CL, N_CL};
         FT_PUSH_PROMISE: return {ER, ER, ER, ER, ER, ER, ER, N_RL};
         FT_SETTINGS, FT_PING, FT_GOAWAY: return ALL_ERR;
         default:         return ALL_KEEP;
      endcase
   endfunction

   function automatic logic [31:0] received_row(input logic [7:0] ft);
      case (ft)
         FT_DATA:         return {KP, KP, KP, ER, KP, ER, ER, ER};
         FT_HEADERS:      return {KP, KP, KP, ER, KP, ER, N_HL, N_OP};
         FT_RST_STREAM:   return {KP, KP, N_CL, N_CL, N_CL, N_CL, N_CL, ER};
         FT_PUSH_PROMISE: return {ER, ER, ER, ER, ER, ER, ER, N_RR};
         FT_SETTINGS, FT_PING, FT_GOAWAY: return ALL_ERR;
         default:         return ALL_KEEP;
      endcase
   endfunction

   function automatic logic [31:0] event_row(input logic [1:0] ev);
      case (ev)
         EV_CLOSED_LOCAL:  return {ER, ER, ER, N_CL, N_HL, ER, ER, ER};
         EV_CLOSED_REMOTE: return {KP, KP, N_CL, ER, N_HR, ER, ER, ER};
         EV_CANCEL:        return {KP, KP, N_CL, N_CL, N_CL, N_CL, N_CL, N_CL};
         default:          return {ER, N_CU, N_CL, ER, ER, ER, ER, KP};
      endcase
   endfunction

   function automatic entry_type row_entry(input logic [31:0] row, input logic [2:0] st);
      return row[st*4 +: 4];
   endfunction

   // Applies one entry to the modeled stream; an illegal move from a live
   // stream resets it with INTERNAL_ERROR. Returns 0 on an illegal move.
   function automatic bit take_entry(input entry_type nx);
      if (nx == ER) begin
         flag_bad = 1'b1;
         if (stream_now >= ST_RSVD_REMOTE && stream_now <= ST_HALF_LOCAL) begin
            stream_now = ST_CLOSED;
            stream_err = ERR_INTERNAL;
            flag_rst   = 1'b1;
         end
         return 1'b0;
      end
      if (nx != KP) stream_now = nx[2:0];
      return 1'b1;
   endfunction

   // Moves the modeled stream by one transfer and returns the result it shows.
   function automatic rsp_type advance_stream(input logic [1:0] op, input logic [7:0] ft,
                                              input logic eos, input logic [1:0] ev);
      logic [2:0] prev;
      entry_type  nx;
      rsp_type    r;
      prev     = stream_now;
      flag_bad = 1'b0;
      flag_rst = 1'b0;
      if ((op == OP_SEND || op == OP_RECV) && ft < NUM_FRAMES) begin
         nx = row_entry((op == OP_SEND) ? sent_row(ft) : received_row(ft), stream_now);
         if (nx != ER && op == OP_RECV && ft == FT_HEADERS && stream_now == ST_OPEN && !eos)
         begin
            // Trailer headers without END_STREAM.
            stream_now = ST_CLOSED;
            stream_err = ERR_PROTOCOL;
            flag_rst   = 1'b1;
         end else if (take_entry(nx) && eos && ft <= FT_HEADERS) begin
            // END_STREAM closes our side after a send, the peer's after a receive.
            void'(take_entry(row_entry(event_row((op == OP_SEND) ? EV_CLOSED_LOCAL
                                                                 : EV_CLOSED_REMOTE),
                                       stream_now)));
         end
      end else if (op == OP_EVENT) begin
         void'(take_entry(row_entry(event_row(ev), stream_now)));
      end
      r.stream_state  = stream_now;
      r.status_code   = flag_bad;
      r.reset_error   = stream_err;
      r.reset_now     = flag_rst;
      r.state_changed = (stream_now != prev);
      r.is_closed     = (stream_now >= ST_CLOSED);
      return r;
   endfunction

   function automatic void check_field(input string what, input logic [3:0] want,
                                       input logic [3:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
         mismatches++;
      end
   endfunction

   // Results are checked before the new request is modeled; a request goes through
   // the input register, so its result never comes at the edge that takes it.
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (reset) begin
         stream_now = ST_IDLE;
         stream_err = ERR_NONE;
         stream_reports.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_type'(rsp_tdata[10:0]);
            if (stream_reports.size() == 0) begin
               $display("%0t: result expected none actual %h", $time, rsp_tdata);
               mismatches++;
            end else begin
               want = stream_reports.pop_front();
               check_field("stream_state", 4'(want.stream_state), 4'(got.stream_state));
               check_field("status_code", 4'(want.status_code), 4'(got.status_code));
               check_field("reset_error", want.reset_error, got.reset_error);
               check_field("reset_now", 4'(want.reset_now), 4'(got.reset_now));
               check_field("state_changed", 4'(want.state_changed),
                           4'(got.state_changed));
               check_field("is_closed", 4'(want.is_closed), 4'(got.is_closed));
            end
         end
         if (req_tvalid && req_tready) begin
            stream_reports.push_back(advance_stream(req_tuser, req_tdata[7:0], req_tlast,
                                                    req_tdata[9:8]));
         end
      end
      pending    <= stream_reports.size();
      fail_count <= mismatches;
   end

endmodule

// ----- test/tb_http2_stream_state_tracker.sv -----
// Top of the HTTP/2 stream state tracker testbench: clock, reset, request
// stimulus, result back-pressure, watchdog and the final verdict.
// Depends on h2sst_pkg, the tracker RTL and h2sst_checker.
module tb_http2_stream_state_tracker
   import h2sst_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT   = 2000;
   localparam int RANDOM_PHASES = 4;
   localparam int PHASE_ITEMS   = 113;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic [1:0]  req_tuser = OP_SEND;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   int          fail_count;
   int          pending;
   int          idle_pct = 0;
   int          stall_pct = 0;
   int          quiet_cycles = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   http2_stream_state_tracker dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   h2sst_checker tracker_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // Offers one frame or event, with random idle cycles ahead of it, and
   // returns at the edge where the transfer is taken.
   task automatic offer_frame(input logic [1:0] op, input logic [7:0] ft,
                              input logic eos, input logic [1:0] ev);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {6'd0, ev, ft};
      req_tlast  <= eos;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Holds off new requests until every outstanding result has come back.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // Result side back-pressure.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // Ends the run if nothing moves on either channel for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Idle stream: illegal moves stay put, ignored frames and the unused
      // operation change nothing, END_STREAM on a PRIORITY frame is disregarded.
      offer_frame(OP_SEND, FT_DATA, 1'b0, EV_CLOSED_LOCAL);
      offer_frame(OP_RECV, FT_DATA, 1'b1, EV_EOS_SENT);
      offer_frame(OP_SEND, FT_SETTINGS, 1'b0, EV_CANCEL);
      offer_frame(OP_RECV, FT_GOAWAY, 1'b1, EV_CLOSED_REMOTE);
      offer_frame(OP_EVENT, FT_DATA, 1'b0, EV_CLOSED_LOCAL);
      offer_frame(OP_EVENT, FT_HEADERS, 1'b1, EV_CLOSED_REMOTE);
      offer_frame(OP_EVENT, 8'hff, 1'b0, EV_EOS_SENT);
      offer_frame(OP_UNUSED, 8'hff, 1'b1, EV_EOS_SENT);
      offer_frame(OP_SEND, NUM_FRAMES, 1'b1, EV_CLOSED_LOCAL);
      offer_frame(OP_RECV, 8'hff, 1'b1, EV_CANCEL);
      offer_frame(OP_SEND, FT_PRIORITY, 1'b1, EV_CLOSED_LOCAL);
      offer_frame(OP_RECV, FT_CONTINUATION, 1'b1, EV_CLOSED_LOCAL);

      // Open the stream and exchange frames that keep it open.
      offer_frame(OP_RECV, FT_HEADERS, 1'b0, EV_CLOSED_LOCAL);
      offer_frame(OP_SEND, FT_DATA, 1'b0, EV_CLOSED_LOCAL);
      offer_frame(OP_RECV, FT_DATA, 1'b0, EV_CLOSED_LOCAL);
      offer_frame(OP_SEND, FT_HEADERS, 1'b0, EV_CLOSED_LOCAL);
      offer_frame(OP_RECV, FT_WINDOW_UPDATE, 1'b1, EV_CLOSED_LOCAL);

      // Trailer headers without END_STREAM reset the stream.
      offer_frame(OP_RECV, FT_HEADERS, 1'b0, EV_CLOSED_LOCAL);

      // Closed stream: cancel and peer reset keep it, an illegal follow-on close
      // is only flagged, then cleanup and an illegal move out of cleanup.
      offer_frame(OP_EVENT, FT_DATA, 1'b0, EV_CANCEL);
      offer_frame(OP_RECV, FT_RST_STREAM, 1'b0, EV_CLOSED_LOCAL);
      offer_frame(OP_SEND, FT_DATA, 1'b1, EV_CLOSED_LOCAL);
      offer_frame(OP_RECV, FT_PUSH_PROMISE, 1'b0, EV_CLOSED_LOCAL);
      offer_frame(OP_EVENT, FT_DATA, 1'b0, EV_EOS_SENT);
      offer_frame(OP_EVENT, FT_DATA, 1'b0, EV_EOS_SENT);
      offer_frame(OP_SEND, FT_RST_STREAM, 1'b1, EV_CLOSED_LOCAL);

      // Random transfers under each mix of idle and stall, draining between.
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         drain_results();
         case (ph)
            0: begin
               idle_pct = 0;
               stall_pct <= 0;
            end
            1: begin
               idle_pct = 51;
               stall_pct <= 0;
            end
            2: begin
               idle_pct = 0;
               stall_pct <= 51;
            end
            default: begin
               idle_pct = 11;
               stall_pct <= 11;
            end
         endcase
         repeat (PHASE_ITEMS) begin
            offer_frame(2'($urandom_range(0, 3)),
                        $urandom_range(0, 1) ? 8'($urandom_range(0, 9))
                                             : 8'($urandom_range(0, 255)),
                        1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
         end
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
